>>> hdl/circular_deque_assert.svh
// assertion macros used by the rtl in circular_deque.sv
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cdq_pkg.sv
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CAP_W  = 5;
    localparam int WORD_W = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // register indexes
    localparam logic REG_CAPACITY = 1'b0;

    // opcodes
    localparam logic [1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [WORD_W-1:0] push_value;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] pop_value;
        logic [CAP_W-1:0]         occupancy;
    } t_out;

    typedef struct packed {
        logic [CAP_W-1:0] cap_eff;
        logic             clear;
    } t_cfg;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                   input logic [CAP_W-1:0] cap);
        logic [IDX_W-1:0] res;
        if (int'(idx) + 1 >= int'(cap)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx,
                                                   input logic [CAP_W-1:0] cap);
        logic [IDX_W-1:0] res;
        if (idx == '0 || int'(idx) > int'(cap)) begin
            res = IDX_W'(cap - 1'b1);
        end else begin
            res = idx - 1'b1;
        end
        return res;
    endfunction

endpackage

>>> hdl/cdq_ram.sv
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/cdq_cfg.sv
module cdq_cfg
    import cdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [CAP_W-1:0] r_capacity;
    logic             w_wr_cap;

    assign pready   = 1'b1;
    assign w_wr_cap = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (w_wr_cap) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // zero acts as one, anything past the ring size acts as the ring size
    always_comb begin
        if (r_capacity == '0) begin
            o_cfg.cap_eff = CAP_W'(1);
        end else if (int'(r_capacity) > DEPTH) begin
            o_cfg.cap_eff = CAP_W'(DEPTH);
        end else begin
            o_cfg.cap_eff = r_capacity;
        end
        o_cfg.clear = w_wr_cap;
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(r_capacity) : '0;

endmodule

>>> hdl/circular_deque.sv
// results: each transaction is registered in the pending register, then in the output register
// throughput: one transaction per cycle while the result side drains, with the
//   read of the slot memory overlapping the next transaction
// reset: head, tail and count go to zero and capacity to 16; the slot memory is
//   not cleared and needs no clearing pass, a slot is popped only after a push
`include "circular_deque_assert.svh"

module circular_deque
    import cdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg w_cfg;

    // ring pointers and fill level
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CAP_W-1:0] r_count, n_count;

    // transaction waiting for its memory read
    logic             r_pend;
    logic [1:0]       r_pend_status, n_pend_status;
    logic             r_pend_pop, n_pend_pop;
    logic [CAP_W-1:0] r_pend_occ;

    // output register
    logic             r_out_valid;
    t_out             r_out;

    // slot memory access
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic             w_re;
    logic [IDX_W-1:0] w_raddr;
    logic [WORD_W-1:0] w_rdata;

    logic w_accept;
    logic w_load;
    logic w_is_push;
    logic w_full;
    logic w_empty;

    cdq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in_data.push_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // the pending result moves out when the output register is free or emptying
    assign w_load      = r_pend && (!r_out_valid || !i_out_stall);
    // a new transaction is taken in the same cycle the pending one moves out
    assign o_in_stall  = r_pend && !w_load;
    assign w_accept    = i_in_valid && !o_in_stall;

    assign w_is_push = (i_in_data.opcode == OP_PUSH_REAR) ||
                       (i_in_data.opcode == OP_PUSH_FRONT);
    assign w_full    = r_count >= w_cfg.cap_eff;
    assign w_empty   = r_count == '0;

    // pointer update and memory request for the transaction being taken
    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_pend_status = ST_DONE;
        n_pend_pop    = 1'b0;
        w_we          = 1'b0;
        w_waddr       = '0;
        w_re          = 1'b0;
        w_raddr       = r_head;
        if (w_is_push) begin
            if (w_full) begin
                n_pend_status = ST_FULL;
            end else begin
                w_we    = w_accept;
                n_count = r_count + 1'b1;
                if (w_empty) begin
                    // first entry always lands in slot zero
                    n_head  = '0;
                    n_tail  = '0;
                    w_waddr = '0;
                end else if (i_in_data.opcode == OP_PUSH_REAR) begin
                    n_tail  = ring_next(r_tail, w_cfg.cap_eff);
                    w_waddr = n_tail;
                end else begin
                    n_head  = ring_prev(r_head, w_cfg.cap_eff);
                    w_waddr = n_head;
                end
            end
        end else begin
            if (w_empty) begin
                n_pend_status = ST_EMPTY;
            end else begin
                w_re       = w_accept;
                n_pend_pop = 1'b1;
                n_count    = r_count - 1'b1;
                if (i_in_data.opcode == OP_POP_FRONT) begin
                    w_raddr = r_head;
                    if (r_count > CAP_W'(1)) begin
                        n_head = ring_next(r_head, w_cfg.cap_eff);
                    end
                end else begin
                    w_raddr = r_tail;
                    if (r_count > CAP_W'(1)) begin
                        n_tail = ring_prev(r_tail, w_cfg.cap_eff);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (w_cfg.clear) begin
            // a capacity write empties the queue
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (w_accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (w_accept) begin
            r_pend <= 1'b1;
        end else if (w_load) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_status <= n_pend_status;
            r_pend_pop    <= n_pend_pop;
            r_pend_occ    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // read data is ready the cycle after the request
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.status    <= r_pend_status;
            r_out.pop_value <= r_pend_pop ? w_rdata : '0;
            r_out.occupancy <= r_pend_occ;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CDQ_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1,
        r_count <= w_cfg.cap_eff, "fill level above capacity")
    `CDQ_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n,
        w_accept && w_is_push && !w_full,
        r_count == $past(r_count) + 1'b1, "accepted push did not add an entry")
    `CDQ_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load,
        o_out_valid, "pending result not shown")
    `CDQ_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n,
        o_out_valid && (o_out_data.status != ST_DONE),
        o_out_data.pop_value == '0, "rejected transaction returned a word")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench
    import cdq_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 200;
    localparam int CHUNKS        = 6;
    localparam int CHUNK_ITEMS   = 61;
    localparam int DRAIN_CYCLES  = 10;

    // golden deque: own copy of the ring, the indexes and the capacity register
    class deque_tracker;
        logic [CAP_W-1:0]  cap_reg;
        logic [IDX_W-1:0]  front_slot;
        logic [IDX_W-1:0]  rear_slot;
        logic [CAP_W-1:0]  stored;
        logic [WORD_W-1:0] ring [DEPTH];
        t_out              pending_results [$];
        int                mismatches;
        int                checked;
        int                full_rejects;
        int                empty_rejects;
        int                pops_done;

        function new();
            cap_reg = CAP_RESET;
            empty_ring();
            foreach (ring[i]) ring[i] = '0;
            mismatches    = 0;
            checked       = 0;
            full_rejects  = 0;
            empty_rejects = 0;
            pops_done     = 0;
        endfunction

        function void empty_ring();
            front_slot = '0;
            rear_slot  = '0;
            stored     = '0;
        endfunction

        // a capacity write also drops every stored entry
        function void set_capacity(input logic [CAP_W-1:0] value);
            cap_reg = value;
            empty_ring();
        endfunction

        // zero acts as one, anything past the ring size as the ring size
        function int slots_in_use();
            if (cap_reg == 0) return 1;
            if (int'(cap_reg) > DEPTH) return DEPTH;
            return int'(cap_reg);
        endfunction

        function int step_fwd(input int idx, input int lim);
            return (idx + 1 >= lim) ? 0 : idx + 1;
        endfunction

        function int step_back(input int idx, input int lim);
            return (idx == 0 || idx > lim) ? lim - 1 : idx - 1;
        endfunction

        function void take_request(input t_in req);
            int   lim;
            int   slot;
            t_out res;
            lim = slots_in_use();
            res = '0;
            res.status = ST_DONE;
            if (req.opcode == OP_PUSH_REAR || req.opcode == OP_PUSH_FRONT) begin
                if (int'(stored) >= lim) begin
                    res.status = ST_FULL;
                    full_rejects++;
                end else begin
                    if (stored == 0) begin
                        // first entry always lands in slot zero
                        front_slot = '0;
                        rear_slot  = '0;
                        slot       = 0;
                    end else if (req.opcode == OP_PUSH_REAR) begin
                        rear_slot = IDX_W'(step_fwd(int'(rear_slot), lim));
                        slot      = int'(rear_slot);
                    end else begin
                        front_slot = IDX_W'(step_back(int'(front_slot), lim));
                        slot       = int'(front_slot);
                    end
                    ring[slot] = req.push_value;
                    stored++;
                end
            end else begin
                if (stored == 0) begin
                    res.status = ST_EMPTY;
                    empty_rejects++;
                end else begin
                    // the last pop leaves both indexes where they are
                    if (req.opcode == OP_POP_FRONT) begin
                        res.pop_value = ring[front_slot];
                        if (stored > 1) front_slot = IDX_W'(step_fwd(int'(front_slot), lim));
                    end else begin
                        res.pop_value = ring[rear_slot];
                        if (stored > 1) rear_slot = IDX_W'(step_back(int'(rear_slot), lim));
                    end
                    stored--;
                    pops_done++;
                end
            end
            res.occupancy = stored;
            pending_results.push_back(res);
        endfunction

        function void match_response(input t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d pop_value %0d occupancy %0d",
                       got.status, got.pop_value, got.occupancy);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.pop_value !== want.pop_value) begin
                $error("pop_value: expected %0d, actual %0d", want.pop_value, got.pop_value);
                mismatches++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
                mismatches++;
            end
        endfunction
    endclass

    // clock, reset and every dut input start at known values
    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in               i_in_data   = '0;
    logic              i_out_stall = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    t_out              o_out_data;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    deque_tracker tracker = new();

    // idle rates in percent for the source and the sink side
    int  source_idle_pct = 0;
    int  sink_idle_pct   = 0;
    // one-shot request for a long sink hold-off, counted down by the sink process
    bit  hold_off_req    = 1'b0;
    int  hold_left       = 0;
    int  cycle_count     = 0;
    int  settings_seen   = 0;

    circular_deque u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: take the transaction seen at this edge, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.match_response(o_out_data);
        end
        if (hold_off_req) begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // offer one transaction, with random gaps in front, and hold it until taken
    task automatic send_request(input logic [1:0] op, input logic [WORD_W-1:0] value);
        t_in req;
        req.opcode     = op;
        req.push_value = value;
        while ($urandom_range(99) < source_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_request(req);
    endtask

    // capacity is only written once the block has drained
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        logic [DATA_W-1:0] word;
        i_in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        // upper data bits are don't-care, so scramble them
        word = $urandom();
        word = {word[DATA_W-1:CAP_W], value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(REG_CAPACITY));
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_capacity(value);
        settings_seen++;
    endtask

    // random word, leaning on the sign and all-ones/all-zeros corners
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [1:0] pick_opcode(input int push_pct);
        if ($urandom_range(99) < push_pct) begin
            return $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        end
        return $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
    endfunction

    // one idle phase: chunks that each start from a fresh capacity, fill up, then drain
    task automatic run_phase(input int phase);
        logic [CAP_W-1:0] corner_caps [8];
        logic [CAP_W-1:0] cap;
        int               fill_pct;
        int               drain_pct;
        corner_caps = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd15, 5'd16, 5'd17, 5'd31};
        for (int c = 0; c < CHUNKS; c++) begin
            if (c % 2 == 0) begin
                cap = corner_caps[(phase * CHUNKS + c) / 2 % 8];
            end else begin
                cap = CAP_W'($urandom_range(31));
            end
            write_capacity(cap);
            // long sink hold-off while the source keeps pushing, so the input backs up
            if (phase == 2 && c == 0) hold_off_req = 1'b1;
            fill_pct  = $urandom_range(60, 90);
            drain_pct = $urandom_range(10, 40);
            for (int k = 0; k < CHUNK_ITEMS; k++) begin
                send_request(pick_opcode(k < CHUNK_ITEMS / 2 ? fill_pct : drain_pct),
                             pick_word());
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        source_idle_pct = 11;
        sink_idle_pct   = 73;

        // directed: empty pops, extreme words from both ends, last entry popped
        send_request(OP_POP_FRONT,  32'h0000_0000);
        send_request(OP_POP_REAR,   32'hffff_ffff);
        send_request(OP_PUSH_REAR,  32'h7fff_ffff);
        send_request(OP_PUSH_FRONT, 32'h8000_0000);
        send_request(OP_PUSH_REAR,  32'hffff_ffff);
        send_request(OP_PUSH_FRONT, 32'h0000_0000);
        send_request(OP_POP_REAR,   32'h1234_5678);
        send_request(OP_POP_FRONT,  32'h0);
        send_request(OP_POP_FRONT,  32'h0);
        send_request(OP_POP_REAR,   32'h0);
        send_request(OP_POP_FRONT,  32'h0);
        // capacity zero behaves as a single slot: full after one push
        write_capacity(5'd0);
        send_request(OP_PUSH_REAR,  32'h5555_5555);
        send_request(OP_PUSH_FRONT, 32'haaaa_aaaa);
        send_request(OP_PUSH_REAR,  32'haaaa_aaaa);
        send_request(OP_POP_REAR,   32'h0);
        send_request(OP_POP_FRONT,  32'h0);
        // two slots: front pushes wrap backwards through the ring
        write_capacity(5'd2);
        send_request(OP_PUSH_FRONT, 32'hdead_beef);
        send_request(OP_PUSH_FRONT, 32'h0bad_cafe);
        send_request(OP_PUSH_REAR,  32'h1111_1111);
        send_request(OP_POP_FRONT,  32'h0);
        send_request(OP_POP_FRONT,  32'h0);
        // a capacity write drops whatever is stored; above the ring size acts as full size
        send_request(OP_PUSH_REAR,  32'h0f0f_0f0f);
        send_request(OP_PUSH_REAR,  32'hf0f0_f0f0);
        write_capacity(5'd31);
        send_request(OP_POP_FRONT,  32'h0);
        send_request(OP_PUSH_FRONT, 32'h8000_0001);

        // random part, three idle profiles in turn
        run_phase(0);
        source_idle_pct = 73;
        sink_idle_pct   = 11;
        run_phase(1);
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        run_phase(2);

        i_in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results across %0d capacity settings", tracker.checked,
                 settings_seen);
        $display("pops %0d, rejected full %0d, rejected empty %0d", tracker.pops_done,
                 tracker.full_rejects, tracker.empty_rejects);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
